// ----- sv/aifp_pkg.sv -----
// Shared types and constants for the ASCII integer field parser.
package aifp_pkg;

  // Base selection codes, used both by the configuration register and the parser.
  typedef enum logic [1:0] {
    BASE_AUTO = 2'd0,
    BASE_OCT  = 2'd1,
    BASE_DEC  = 2'd2,
    BASE_HEX  = 2'd3
  } base_t;

  // Parser phase within one field.
  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_SIGNED = 2'd1,
    PH_ZERO   = 2'd2,
    PH_DIGITS = 2'd3
  } phase_t;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_MODE   = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FIELD_WIDTH = 1'd1;
  localparam int unsigned CFG_DATA_BITS = 8;

  localparam base_t      BASE_MODE_RST   = BASE_DEC;
  localparam logic [7:0] FIELD_WIDTH_RST = 8'd0;

  // Characters the classifier looks for.
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_UP_X  = 8'h58;

  localparam logic [15:0] CONSUMED_MAX = 16'hFFFF;

  // Queue between the classifier and the parser.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_BITS   = 1;

  // One classified character.
  typedef struct packed {
    logic       is_plus;
    logic       is_minus;
    logic       is_zero;
    logic       is_x;
    logic       is_hex;   // 0-9, a-f or A-F
    logic [3:0] dig;      // digit value when is_hex
  } cls_t;

endpackage

// ----- sv/aifp_front.sv -----
// Input side of the parser: accepts characters and classifies them.
module aifp_front import aifp_pkg::*; (
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       q_full,
  output logic       q_push,
  output cls_t       q_item
);

  logic [7:0] dec_off;
  logic [7:0] lo_off;
  logic [7:0] up_off;
  logic       is_dec;
  logic       is_lo;
  logic       is_up;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  assign dec_off = in_ch - CH_ZERO;
  assign lo_off  = in_ch - CH_LO_A + 8'd10;
  assign up_off  = in_ch - CH_UP_A + 8'd10;
  assign is_dec  = (in_ch >= CH_ZERO) && (in_ch <= CH_NINE);
  assign is_lo   = (in_ch >= CH_LO_A) && (in_ch <= CH_LO_F);
  assign is_up   = (in_ch >= CH_UP_A) && (in_ch <= CH_UP_F);

  always_comb begin
    q_item.is_plus  = (in_ch == CH_PLUS);
    q_item.is_minus = (in_ch == CH_MINUS);
    q_item.is_zero  = (in_ch == CH_ZERO);
    q_item.is_x     = (in_ch == CH_LO_X) || (in_ch == CH_UP_X);
    q_item.is_hex   = is_dec || is_lo || is_up;
    if (is_dec) begin
      q_item.dig = dec_off[3:0];
    end else if (is_lo) begin
      q_item.dig = lo_off[3:0];
    end else begin
      q_item.dig = up_off[3:0];
    end
  end

endmodule

// ----- sv/aifp_queue.sv -----
// Two-entry queue of classified characters between front and back.
module aifp_queue import aifp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cls_t push_item,
  output logic full,
  output logic valid,
  output cls_t item,
  input  logic pop
);

  cls_t                 mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r;
  logic [QPTR_BITS-1:0] rd_ptr_r;
  logic [QPTR_BITS:0]   count_r;

  assign full  = (count_r == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign valid = (count_r != '0);
  assign item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- sv/aifp_back.sv -----
// Parser back end: field state machine, digit accumulation and result register.
module aifp_back import aifp_pkg::*; #(
  parameter int unsigned VALUE_BITS = 64,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  base_t                 base_mode,
  input  logic [7:0]            field_width,
  input  logic                  q_valid,
  input  cls_t                  q_item,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_ok,
  output logic signed [63:0]    out_number,
  output logic [15:0]           out_consumed,
  output logic                  out_took_char
);

  phase_t                phase_r, phase_nxt;
  logic                  neg_r, neg_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic                  seen_r, seen_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [7:0]            wleft_r, wleft_nxt;
  base_t                 base_r, base_nxt;
  logic                  unlim_r, unlim_nxt;

  logic                  out_valid_r;
  logic                  out_ok_r;
  logic                  out_neg_r;
  logic [VALUE_BITS-1:0] out_acc_r;
  logic [15:0]           out_cons_r;
  logic                  out_took_r;

  phase_t                ph_a;
  logic                  handled;
  logic                  judge;
  logic                  take;
  logic                  spent_on_take;
  logic                  dig_fits;
  logic [VALUE_BITS-1:0] prod;
  logic                  emit;
  logic                  res_ok;
  logic                  res_took;
  logic [31:0]           cnt_wide;
  logic [15:0]           res_cons;
  logic signed [VALUE_BITS-1:0] val_s;

  logic back_ready;

  assign back_ready = !out_valid_r || out_ready;
  assign q_pop      = q_valid && back_ready;

  always_comb begin
    ph_a      = phase_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    seen_nxt  = seen_r;
    wleft_nxt = wleft_r;
    base_nxt  = base_r;
    unlim_nxt = unlim_r;
    phase_nxt = phase_r;
    handled   = 1'b0;
    judge     = 1'b0;
    take      = 1'b0;
    emit      = 1'b0;
    res_ok    = 1'b0;
    res_took  = 1'b0;
    prod      = '0;
    dig_fits  = 1'b0;
    cnt_nxt   = cnt_r;

    // A new field reloads the working state from the configuration.
    if (phase_r == PH_START) begin
      unlim_nxt = (field_width == 8'd0);
      wleft_nxt = field_width;
      base_nxt  = base_mode;
      neg_nxt   = 1'b0;
      acc_nxt   = '0;
      seen_nxt  = 1'b0;
      cnt_nxt   = '0;
      ph_a      = PH_SIGNED;
    end

    // Taking a character empties the width when one or none is left.
    spent_on_take = !unlim_nxt && (wleft_nxt <= 8'd1);

    if (phase_r == PH_START && (q_item.is_plus || q_item.is_minus)) begin
      handled = 1'b1;
      neg_nxt = q_item.is_minus;
      take    = 1'b1;
      if (spent_on_take) begin
        emit      = 1'b1;
        phase_nxt = PH_START;
      end else begin
        phase_nxt = PH_SIGNED;
      end
    end

    if (!handled) begin
      unique case (ph_a)
        PH_SIGNED: begin
          if (q_item.is_zero && (base_nxt == BASE_AUTO || base_nxt == BASE_HEX) &&
              (unlim_nxt || wleft_nxt >= 8'd2)) begin
            // Hold the zero until we know whether an x follows.
            take      = 1'b1;
            phase_nxt = PH_ZERO;
          end else begin
            if (base_nxt == BASE_AUTO) begin
              base_nxt = q_item.is_zero ? BASE_OCT : BASE_DEC;
            end
            judge = 1'b1;
          end
        end
        PH_ZERO: begin
          if (q_item.is_x) begin
            base_nxt = BASE_HEX;
            take     = 1'b1;
            if (spent_on_take) begin
              emit      = 1'b1;
              phase_nxt = PH_START;
            end else begin
              phase_nxt = PH_DIGITS;
            end
          end else begin
            // The held zero was a plain digit.
            if (base_nxt == BASE_AUTO) begin
              base_nxt = BASE_OCT;
            end
            seen_nxt = 1'b1;
            acc_nxt  = '0;
            judge    = 1'b1;
          end
        end
        PH_DIGITS: begin
          judge = 1'b1;
        end
        default: begin
          judge = 1'b0;
        end
      endcase
    end

    if (judge) begin
      unique case (base_nxt)
        BASE_OCT: begin
          dig_fits = q_item.is_hex && !q_item.dig[3];
          prod     = acc_nxt << 3;
        end
        BASE_HEX: begin
          dig_fits = q_item.is_hex;
          prod     = acc_nxt << 4;
        end
        default: begin
          dig_fits = q_item.is_hex && (q_item.dig <= 4'd9);
          prod     = (acc_nxt << 3) + (acc_nxt << 1);
        end
      endcase
      if (dig_fits) begin
        acc_nxt  = prod + VALUE_BITS'(q_item.dig);
        seen_nxt = 1'b1;
        take     = 1'b1;
        if (spent_on_take) begin
          emit      = 1'b1;
          res_ok    = 1'b1;
          res_took  = 1'b1;
          phase_nxt = PH_START;
        end else begin
          phase_nxt = PH_DIGITS;
        end
      end else begin
        emit      = 1'b1;
        res_ok    = seen_nxt;
        phase_nxt = PH_START;
      end
    end

    if (take) begin
      if (cnt_nxt != '1) begin
        cnt_nxt = cnt_nxt + 1'b1;
      end
      if (!unlim_nxt && wleft_nxt != 8'd0) begin
        wleft_nxt = wleft_nxt - 8'd1;
      end
    end

    cnt_wide = 32'(cnt_nxt);
    if (!res_ok) begin
      res_cons = '0;
    end else if (cnt_wide > 32'(CONSUMED_MAX)) begin
      res_cons = CONSUMED_MAX;
    end else begin
      res_cons = cnt_wide[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      neg_r   <= 1'b0;
      acc_r   <= '0;
      seen_r  <= 1'b0;
      cnt_r   <= '0;
      wleft_r <= 8'd0;
      base_r  <= BASE_AUTO;
      unlim_r <= 1'b0;
    end else if (q_pop) begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      acc_r   <= acc_nxt;
      seen_r  <= seen_nxt;
      cnt_r   <= cnt_nxt;
      wleft_r <= wleft_nxt;
      base_r  <= base_nxt;
      unlim_r <= unlim_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      out_ok_r   <= res_ok;
      out_neg_r  <= neg_nxt;
      out_acc_r  <= res_ok ? acc_nxt : '0;
      out_cons_r <= res_cons;
      out_took_r <= res_took;
    end
  end

  // Negation and sign extension sit after the result register.
  assign val_s         = out_neg_r ? -out_acc_r : out_acc_r;
  assign out_valid     = out_valid_r;
  assign out_ok        = out_ok_r;
  assign out_number    = 64'(val_s);
  assign out_consumed  = out_cons_r;
  assign out_took_char = out_took_r;

endmodule

// ----- sv/ascii_integer_field_parser_core.sv -----
// Accepted characters are written into the two-entry queue; the parser pops them from there,
// and a field's result is registered in the result register that drives out_valid.
// Throughput: one character per cycle; the input stalls only while a result waits on out_ready
// and the queue has filled behind it. Each digit is a shift-and-add (two shifts in decimal).
// Reset (rst_n low, synchronous) empties the queue, drops any pending result, returns the
// parser to the start of a field and sets base_mode to decimal and field_width to unlimited.
module ascii_integer_field_parser_core import aifp_pkg::*; #(
  parameter int unsigned VALUE_BITS = 64,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_ch,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_ok,
  output logic signed [63:0]       out_number,
  output logic [15:0]              out_consumed,
  output logic                     out_took_char,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  // The configuration registers are sampled by the parser when a field's first
  // item reaches it. Writes must arrive only while the block is idle; the block
  // itself does not enforce this. The parser reads the registers directly.
  base_t      base_mode_r;
  logic [7:0] field_width_r;

  cls_t q_in_item;
  cls_t q_out_item;
  logic q_push;
  logic q_full;
  logic q_valid;
  logic q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_mode_r   <= BASE_MODE_RST;
      field_width_r <= FIELD_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE_MODE:   base_mode_r   <= base_t'(cfg_data[1:0]);
        CFG_FIELD_WIDTH: field_width_r <= cfg_data[7:0];
        default:         base_mode_r   <= base_mode_r;
      endcase
    end
  end

  // The front end classifies each character: sign, zero, x, and hex digit value.
  aifp_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in_item)
  );

  // The queue lets the input keep flowing while the result side stalls briefly.
  aifp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .valid     (q_valid),
    .item      (q_out_item),
    .pop       (q_pop)
  );

  // The back end runs the field state machine, one classified item per cycle,
  // and stalls only while its result register holds a result nobody has taken.
  aifp_back #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .base_mode     (base_mode_r),
    .field_width   (field_width_r),
    .q_valid       (q_valid),
    .q_item        (q_out_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_ok        (out_ok),
    .out_number    (out_number),
    .out_consumed  (out_consumed),
    .out_took_char (out_took_char)
  );

endmodule

// ----- sv/aifp_checker.sv -----
// Port-level checks for the ASCII integer field parser, bound to the top level.
module aifp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_ok,
  input logic signed [63:0] out_number,
  input logic [15:0]        out_consumed,
  input logic               out_took_char
);

  // A result waiting for the consumer is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A failed field reports nothing consumed and a zero value.
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_consumed == 16'd0 && !out_took_char && out_number == 64'sd0)
    else $error("failed field carries data");

  // Only a successful field can keep the current character.
  a_took_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_took_char |-> out_ok)
    else $error("character taken by a failed field");

  // A successful field consumed at least its digit.
  a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ok |-> out_consumed != 16'd0)
    else $error("successful field consumed nothing");

  // Reset drops any pending result.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind ascii_integer_field_parser_core aifp_checker u_aifp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_ok        (out_ok),
  .out_number    (out_number),
  .out_consumed  (out_consumed),
  .out_took_char (out_took_char)
);
